### design/pbpa_pkg.sv
// Shared types and constants for the paged block pool allocator.
// Used by pbpa_link_ram and paged_block_pool_allocator; depends on nothing.
`timescale 1ns / 1ps

package pbpa_pkg;

	// Pool geometry
	localparam int MAX_PAGES           = 16;
	localparam int MAX_BLOCKS_PER_PAGE = 256;
	localparam int MIN_BLOCKS_PER_PAGE = 16;
	localparam int LINK_DEPTH          = MAX_PAGES * MAX_BLOCKS_PER_PAGE;

	// Field widths
	localparam int PAGE_W  = 4;
	localparam int SLOT_W  = 8;
	localparam int IDX_W   = PAGE_W + SLOT_W;
	localparam int BPP_W   = 9;
	localparam int PAGES_W = 5;
	localparam int FUNC_W  = 2;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [BPP_W-1:0]   BPP_RESET = BPP_W'(16);
	localparam logic [BPP_W-1:0]   BPP_MIN   = BPP_W'(MIN_BLOCKS_PER_PAGE);
	localparam logic [BPP_W-1:0]   BPP_MAX   = BPP_W'(MAX_BLOCKS_PER_PAGE);
	localparam logic [PAGES_W-1:0] PAGES_MAX = PAGES_W'(MAX_PAGES);

	// Register index, taken from the word address bit
	localparam logic REG_BPP = 1'b0;

	// Request kinds
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_RESET = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_POP  = 1'b1
	} state_t;

	// One entry of the link store: next block on the free list and its valid flag
	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] link;
	} link_entry_t;

endpackage

### design/pbpa_link_ram.sv
// Link store of the free list: one synchronous memory, one write and one read port.
// Depends on pbpa_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pbpa_link_ram
	import pbpa_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  link_entry_t      wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output link_entry_t      rdata
);

	link_entry_t mem_q [LINK_DEPTH];
	link_entry_t rdata_q;

	// Write port; contents are undefined until written
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/paged_block_pool_allocator.sv
// Paged fixed-size block pool allocator.
//
// Requests arrive on the in_valid/in_ready channel (func, page, slot) and each
// produces exactly one result transaction on out_valid/out_ready (status,
// block_page, block_slot). An alloc hands out a block from the LIFO free list,
// otherwise the next slot of the current page counting down, opening further
// pages as needed; status 1 means the pool is exhausted. Free pushes a block on
// the list, reset rewinds the pool to page 0 without forgetting opened pages.
// A pop from the free list goes through the ST_POP state, as the head's link
// comes from the synchronous link memory; every other request loads its result
// straight from ST_IDLE. The next request is taken once the current one has
// placed its result in the output register. While the receiver stalls the result
// holds in that register and in_ready drops until it is taken. blocks_per_page is
// written over the APB-style port at address 0 and is clamped to 16..256.
// After arst_n the list is empty, page 0 holds 16 blocks and one page is open;
// the link memory needs no clearing pass.
// Depends on pbpa_pkg and pbpa_link_ram.
`timescale 1ns / 1ps

module paged_block_pool_allocator
	import pbpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [PAGE_W-1:0]  page,
	input  logic [SLOT_W-1:0]  slot,
	// Result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [PAGE_W-1:0]  block_page,
	output logic [SLOT_W-1:0]  block_slot,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	state_t              state_q, state_d;
	logic [BPP_W-1:0]    bpp_q;
	logic [IDX_W-1:0]    free_head_q, free_head_d;
	logic                head_valid_q, head_valid_d;
	logic [PAGE_W-1:0]   cur_page_q, cur_page_d;
	logic [BPP_W-1:0]    blocks_left_q, blocks_left_d;
	logic [PAGES_W-1:0]  pages_made_q, pages_made_d;

	logic                out_valid_q;
	logic                status_q;
	logic [PAGE_W-1:0]   block_page_q;
	logic [SLOT_W-1:0]   block_slot_q;

	logic                accept;
	logic                load_out;
	logic                res_status;
	logic [PAGE_W-1:0]   res_page;
	logic [SLOT_W-1:0]   res_slot;
	logic [BPP_W-1:0]    eff_bpp;
	logic [BPP_W-1:0]    eff_bpp_m1;
	logic [BPP_W-1:0]    blocks_left_dec;
	logic [PAGES_W-1:0]  cur_page_inc;
	logic                cfg_write;
	logic                reg_hit;

	logic                ram_we;
	logic                ram_re;
	link_entry_t         ram_wdata;
	link_entry_t         ram_rdata;

	// Configuration register
	assign pready    = 1'b1;
	assign reg_hit   = (paddr[2] == REG_BPP) && (paddr[1:0] == 2'b00);
	assign cfg_write = psel && penable && pwrite && pready && reg_hit;
	assign prdata    = reg_hit ? PDATA_W'(bpp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_RESET;
		end else if (cfg_write) begin
			bpp_q <= pwdata[BPP_W-1:0];
		end
	end

	// Effective page size, clamped to the supported range
	always_comb begin
		if (bpp_q < BPP_MIN) begin
			eff_bpp = BPP_MIN;
		end else if (bpp_q > BPP_MAX) begin
			eff_bpp = BPP_MAX;
		end else begin
			eff_bpp = bpp_q;
		end
	end

	assign eff_bpp_m1      = eff_bpp - BPP_W'(1);
	assign blocks_left_dec = blocks_left_q - BPP_W'(1);
	assign cur_page_inc    = {1'b0, cur_page_q} + PAGES_W'(1);

	// A new request is taken only when the sequencer is idle and the output
	// register is empty or being emptied in this cycle.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// Link memory ports: a free writes the old head into the freed entry, a pop
	// reads the head's entry. The sequencer holds off requests during a pop, so
	// a read never overlaps a write to the same entry.
	assign ram_wdata.ok   = head_valid_q;
	assign ram_wdata.link = free_head_q;

	pbpa_link_ram u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({page, slot}),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (free_head_q),
		.rdata (ram_rdata)
	);

	// Sequencer: next state, pool state updates and the result
	always_comb begin
		state_d       = state_q;
		free_head_d   = free_head_q;
		head_valid_d  = head_valid_q;
		cur_page_d    = cur_page_q;
		blocks_left_d = blocks_left_q;
		pages_made_d  = pages_made_q;
		load_out      = 1'b0;
		res_status    = 1'b0;
		res_page      = '0;
		res_slot      = '0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_t'(func))
						FUNC_ALLOC: begin
							if (head_valid_q) begin
								// Fetch the head's link; the result follows next cycle
								ram_re  = 1'b1;
								state_d = ST_POP;
							end else if (blocks_left_q != '0) begin
								blocks_left_d = blocks_left_dec;
								res_page      = cur_page_q;
								res_slot      = blocks_left_dec[SLOT_W-1:0];
								load_out      = 1'b1;
							end else begin
								load_out = 1'b1;
								priority if (cur_page_inc < pages_made_q) begin
									cur_page_d    = cur_page_inc[PAGE_W-1:0];
									blocks_left_d = eff_bpp_m1;
									res_page      = cur_page_inc[PAGE_W-1:0];
									res_slot      = eff_bpp_m1[SLOT_W-1:0];
								end else if (pages_made_q < PAGES_MAX) begin
									pages_made_d  = pages_made_q + PAGES_W'(1);
									cur_page_d    = cur_page_inc[PAGE_W-1:0];
									blocks_left_d = eff_bpp_m1;
									res_page      = cur_page_inc[PAGE_W-1:0];
									res_slot      = eff_bpp_m1[SLOT_W-1:0];
								end else begin
									// Pool exhausted: no state changes
									res_status = 1'b1;
								end
							end
						end
						FUNC_FREE: begin
							ram_we       = 1'b1;
							free_head_d  = {page, slot};
							head_valid_d = 1'b1;
							load_out     = 1'b1;
						end
						FUNC_RESET: begin
							head_valid_d  = 1'b0;
							free_head_d   = '0;
							cur_page_d    = '0;
							blocks_left_d = eff_bpp;
							load_out      = 1'b1;
						end
						FUNC_NOP: begin
							load_out = 1'b1;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				// Link data has arrived: advance the head and hand out the old one
				free_head_d  = ram_rdata.link;
				head_valid_d = ram_rdata.ok;
				res_page     = free_head_q[IDX_W-1:SLOT_W];
				res_slot     = free_head_q[SLOT_W-1:0];
				load_out     = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			free_head_q   <= '0;
			head_valid_q  <= 1'b0;
			cur_page_q    <= '0;
			blocks_left_q <= BPP_RESET;
			pages_made_q  <= PAGES_W'(1);
		end else begin
			state_q       <= state_d;
			free_head_q   <= free_head_d;
			head_valid_q  <= head_valid_d;
			cur_page_q    <= cur_page_d;
			blocks_left_q <= blocks_left_d;
			pages_made_q  <= pages_made_d;
		end
	end

	// Output register: loaded only when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q     <= res_status;
			block_page_q <= res_page;
			block_slot_q <= res_slot;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign block_page = block_page_q;
	assign block_slot = block_slot_q;

endmodule

### tb/tb_top.sv
// Self-checking testbench for paged_block_pool_allocator: a queue-fed request driver, a
// result monitor and a transaction-level pool predictor, run over several register settings.
// Depends on pbpa_pkg and the RTL of the block under test.
`timescale 1ns / 1ps

module tb_top;
	import pbpa_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int NUM_PHASES  = 8;
	localparam int FILL_ALLOCS = 270;
	localparam logic [PADDR_W-1:0] ADDR_BPP = {REG_BPP, 2'b00};

	typedef struct packed {
		func_t             op;
		logic [PAGE_W-1:0] pg;
		logic [SLOT_W-1:0] sl;
	} request_t;

	typedef struct packed {
		logic              failed;
		logic [PAGE_W-1:0] pg;
		logic [SLOT_W-1:0] sl;
	} reply_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [FUNC_W-1:0]  func     = '0;
	logic [PAGE_W-1:0]  page     = '0;
	logic [SLOT_W-1:0]  slot     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               status;
	logic [PAGE_W-1:0]  block_page;
	logic [SLOT_W-1:0]  block_slot;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Per-phase register value, sender idle and receiver stall percentages, item count,
	// and whether the phase starts by running the pool dry from a rewind.
	int phase_bpp   [NUM_PHASES] = '{0, 511, 16, 256, 17, 257, 5, 100};
	int phase_idle  [NUM_PHASES] = '{0, 54, 0, 18, 54, 0, 18, 0};
	int phase_stall [NUM_PHASES] = '{0, 0, 54, 18, 0, 54, 18, 0};
	int phase_items [NUM_PHASES] = '{140, 140, 100, 140, 140, 140, 100, 140};
	int phase_fill  [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 1, 0};

	request_t          pending_requests[$];
	reply_t            replies_due[$];
	logic [IDX_W-1:0]  live_blocks[$];
	request_t          on_wire = '0;
	int                idle_pct  = 0;
	int                stall_pct = 0;
	int                error_count = 0;
	int                cycle_count = 0;

	// Predictor state: link store, list head, current page and its remaining count.
	logic [IDX_W-1:0]   pool_link    [LINK_DEPTH];
	logic               pool_link_ok [LINK_DEPTH];
	logic [IDX_W-1:0]   pool_head    = '0;
	logic               pool_head_ok = 1'b0;
	logic [PAGE_W-1:0]  pool_page    = '0;
	logic [BPP_W-1:0]   pool_left    = BPP_RESET;
	logic [PAGES_W-1:0] pool_pages   = PAGES_W'(1);
	logic [BPP_W-1:0]   cfg_capacity = BPP_RESET;

	paged_block_pool_allocator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.page       (page),
		.slot       (slot),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.block_page (block_page),
		.block_slot (block_slot),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Blocks per page as actually used, clamped to the legal range.
	function automatic logic [BPP_W-1:0] page_capacity();
		if (cfg_capacity < BPP_MIN) return BPP_MIN;
		if (cfg_capacity > BPP_MAX) return BPP_MAX;
		return cfg_capacity;
	endfunction

	// Applies one request to the predicted pool and returns the result it should give.
	function automatic reply_t pool_serve(request_t rq);
		reply_t           r;
		logic [IDX_W-1:0] idx;
		r = '0;
		case (rq.op)
			FUNC_ALLOC: begin
				if (pool_head_ok) begin
					// Pop the most recently freed block.
					idx          = pool_head;
					pool_head    = pool_link[idx];
					pool_head_ok = pool_link_ok[idx];
					r.pg = idx[IDX_W-1:SLOT_W];
					r.sl = idx[SLOT_W-1:0];
				end else if (pool_left != '0) begin
					pool_left = pool_left - 1'b1;
					r.pg = pool_page;
					r.sl = pool_left[SLOT_W-1:0];
				end else begin
					// Current page is spent: reuse an opened page, open a new one, or give up.
					if (int'(pool_page) + 1 < int'(pool_pages)) begin
						pool_page = pool_page + 1'b1;
					end else if (pool_pages < PAGES_MAX) begin
						pool_pages = pool_pages + 1'b1;
						pool_page  = pool_page + 1'b1;
					end else begin
						r.failed = 1'b1;
						return r;
					end
					pool_left = page_capacity() - 1'b1;
					r.pg = pool_page;
					r.sl = pool_left[SLOT_W-1:0];
				end
			end
			FUNC_FREE: begin
				idx               = {rq.pg, rq.sl};
				pool_link[idx]    = pool_head;
				pool_link_ok[idx] = pool_head_ok;
				pool_head         = idx;
				pool_head_ok      = 1'b1;
			end
			FUNC_RESET: begin
				pool_head_ok = 1'b0;
				pool_head    = '0;
				pool_page    = '0;
				pool_left    = page_capacity();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	task automatic queue_request(input func_t op, input logic [PAGE_W-1:0] pg,
			input logic [SLOT_W-1:0] sl);
		request_t rq;
		rq.op = op;
		rq.pg = pg;
		rq.sl = sl;
		pending_requests.push_back(rq);
	endtask

	// Random page and slot fields for requests that ignore or stress them.
	function automatic logic [PAGE_W-1:0] rand_page();
		return PAGE_W'($urandom_range(15));
	endfunction

	function automatic logic [SLOT_W-1:0] rand_slot();
		return SLOT_W'($urandom_range(255));
	endfunction

	// Frees a block that was handed out earlier, or an arbitrary handle when none is known.
	task automatic queue_free_of_live();
		int               pick;
		logic [IDX_W-1:0] h;
		if (live_blocks.size() == 0) begin
			queue_request(FUNC_FREE, rand_page(), rand_slot());
		end else begin
			pick = $urandom_range(live_blocks.size() - 1);
			h = live_blocks[pick];
			live_blocks.delete(pick);
			queue_request(FUNC_FREE, h[IDX_W-1:SLOT_W], h[SLOT_W-1:0]);
		end
	endtask

	// Adds one random sequence of requests; made counts the requests that the block acts on.
	task automatic add_sequence(inout int made);
		int               kind;
		int               len;
		logic [IDX_W-1:0] h;
		kind = $urandom_range(99);
		if (kind < 45) begin
			len = $urandom_range(12, 1);
			repeat (len) queue_request(FUNC_ALLOC, rand_page(), rand_slot());
			made += len;
		end else if (kind < 75) begin
			len = $urandom_range(8, 1);
			repeat (len) queue_free_of_live();
			made += len;
		end else if (kind < 85) begin
			// Arbitrary handle, often outside the opened pages or beyond the page size.
			queue_request(FUNC_FREE, rand_page(), rand_slot());
			made += 1;
		end else if (kind < 91) begin
			// The same block freed twice in a row.
			h = (live_blocks.size() != 0) ? live_blocks[0] : IDX_W'($urandom);
			queue_request(FUNC_FREE, h[IDX_W-1:SLOT_W], h[SLOT_W-1:0]);
			queue_request(FUNC_FREE, h[IDX_W-1:SLOT_W], h[SLOT_W-1:0]);
			made += 2;
		end else if (kind < 98) begin
			queue_request(FUNC_NOP, rand_page(), rand_slot());
		end else begin
			queue_request(FUNC_RESET, rand_page(), rand_slot());
			live_blocks.delete();
			made += 1;
		end
	endtask

	// Waits until every request has gone in and every result has come out.
	task automatic wait_until_drained();
		while (pending_requests.size() != 0 || in_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write over the configuration port: setup cycle, then access cycle.
	task automatic write_capacity(input logic [BPP_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = $urandom;
		word[BPP_W-1:0] = value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BPP;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_capacity = value;
	endtask

	// Request driver: predicts each accepted transaction and presents the next one.
	always @(posedge clk) begin : p_drive
		request_t next_rq;
		reply_t   want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = pool_serve(on_wire);
				replies_due.push_back(want);
				if (on_wire.op == FUNC_ALLOC && !want.failed)
					live_blocks.push_back({want.pg, want.sl});
			end
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_rq = pending_requests.pop_front();
					in_valid <= 1'b1;
					func     <= next_rq.op;
					page     <= next_rq.pg;
					slot     <= next_rq.sl;
					on_wire  <= next_rq;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted transaction with the oldest prediction.
	always @(posedge clk) begin : p_watch
		reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected result status %0d page %0d slot %0d",
						$time, status, block_page, block_slot);
					error_count++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", int'(want.failed), int'(status));
					check_field("block_page", int'(want.pg), int'(block_page));
					check_field("block_slot", int'(want.sl), int'(block_slot));
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("paged_block_pool_allocator: mismatch");
			$finish;
		end
	end

	initial begin : p_stimulus
		int made;
		foreach (pool_link[i]) begin
			pool_link[i]    = '0;
			pool_link_ok[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening with the reset value of the register.
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		queue_request(FUNC_FREE, 4'd15, 8'd255);   // highest handle, page never opened
		queue_request(FUNC_FREE, 4'd0, 8'd0);
		queue_request(FUNC_ALLOC, 4'd15, 8'd255);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		// Double free of one block: the list then hands it out over and over.
		queue_request(FUNC_FREE, 4'd0, 8'd14);
		queue_request(FUNC_FREE, 4'd0, 8'd14);
		queue_request(FUNC_ALLOC, 4'd5, 8'd170);
		queue_request(FUNC_ALLOC, 4'd10, 8'd85);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		queue_request(FUNC_RESET, 4'd15, 8'd255);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		queue_request(FUNC_NOP, 4'd15, 8'd255);
		// Slot beyond the page size on a page that is not open yet.
		queue_request(FUNC_FREE, 4'd7, 8'd200);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		queue_request(FUNC_FREE, 4'd5, 8'd170);
		queue_request(FUNC_FREE, 4'd10, 8'd85);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		queue_request(FUNC_ALLOC, 4'd0, 8'd0);
		wait_until_drained();

		// Random phases, each under its own register value and handshake pressure.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_capacity(BPP_W'(phase_bpp[ph]));
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			if (phase_fill[ph] != 0) begin
				// Rewind, then allocate past the last block of the last page.
				queue_request(FUNC_RESET, rand_page(), rand_slot());
				live_blocks.delete();
				repeat (FILL_ALLOCS)
					queue_request(FUNC_ALLOC, rand_page(), rand_slot());
			end
			made = 0;
			while (made < phase_items[ph]) begin
				while (pending_requests.size() > 4) @(posedge clk);
				add_sequence(made);
			end
			wait_until_drained();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("paged_block_pool_allocator: match");
		else
			$display("paged_block_pool_allocator: mismatch");
		$finish;
	end

endmodule
